### hdl/longest_wait_thread_scheduler_defines.svh
// ----------------------------------------------------------------------------
// longest_wait_thread_scheduler_defines
// Assertion macros for the longest-wait thread scheduler.
// ----------------------------------------------------------------------------
`ifndef LONGEST_WAIT_THREAD_SCHEDULER_DEFINES_SVH
`define LONGEST_WAIT_THREAD_SCHEDULER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LWTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LWTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LWTS_ASSERT(label, prop, msg)
`define LWTS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### hdl/lwts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lwts_pkg
// Constants and the slot table entry layout of the thread scheduler.
// ----------------------------------------------------------------------------
package lwts_pkg;

  localparam int THREAD_SLOTS_DEF = 64;

  localparam logic [5:0]  TICK_SHIFT_RST   = 6'd10;
  localparam logic [31:0] STAMPS_RST       = 32'd1;
  localparam logic [9:0]  TICK_PERIOD_RST  = 10'd55;

  localparam logic [1:0] REG_TICK_SHIFT  = 2'd0;
  localparam logic [1:0] REG_STAMPS      = 2'd1;
  localparam logic [1:0] REG_TICK_PERIOD = 2'd2;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SWITCH = 1'b1;

  localparam logic [1:0] OUTCOME_BLOCK = 2'd1;
  localparam logic [1:0] OUTCOME_EXIT  = 2'd2;

  localparam logic [14:0] EATER_SCALE  = 15'd20;
  localparam logic [14:0] EATER_OFFSET = 15'd10;

  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic        used;
    logic        runnable;
    logic        excluded;
    logic        penalty;
    logic [63:0] last_tick;
  } slot_entry_t;

endpackage
`default_nettype wire

### hdl/longest_wait_thread_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// longest_wait_thread_scheduler
// Thread slot table with a longest-wait selection scan.
// ----------------------------------------------------------------------------
// Usage: raise start with the request fields while busy is low. A load request
// (kind 0) writes one slot in the accepting cycle and gives no result; busy
// stays low. A switch request (kind 1) stamps the current slot if present,
// scans the table unless a slot is forced, and reports on done for exactly one
// cycle with chosen_slot, chose_idle, eater_flagged and thread_changed.
// During a switch the table scan reads one slot a cycle from the slot memory
// while the elapsed-time divider retires one quotient bit a cycle; done
// follows once both have finished. Configuration: cfg_we writes cfg_data into
// register cfg_index (0 tick shift, 1 stamps per 100 us, 2 tick period in ms);
// the user must write only while the block is idle, the block does not enforce it.
// Reset: after rst falls, a clearing pass writes all THREAD_SLOTS entries,
// one a cycle, with busy high; requests wait for it to end.
// The receiver cannot stall: each result is valid in the done cycle only.
// ----------------------------------------------------------------------------
`include "longest_wait_thread_scheduler_defines.svh"

module longest_wait_thread_scheduler #(
  parameter int THREAD_SLOTS = lwts_pkg::THREAD_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind,
  input  wire logic [5:0]  slot,
  input  wire logic        slot_in_use,
  input  wire logic        runnable,
  input  wire logic        no_schedule,
  input  wire logic [63:0] last_tick,
  input  wire logic [63:0] timestamp,
  input  wire logic        current_present,
  input  wire logic [1:0]  current_outcome,
  input  wire logic        forced_present,
  input  wire logic [5:0]  forced_slot,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             done,
  output logic [5:0]       chosen_slot,
  output logic             chose_idle,
  output logic             eater_flagged,
  output logic             thread_changed
);

  localparam int SLOT_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int CNT_W  = $clog2(THREAD_SLOTS + 1);
  localparam int DCNT_W = $clog2(lwts_pkg::DIV_STEPS + 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_CUR_WR = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_WAIT   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;

  logic [5:0]  tick_shift;
  logic [31:0] stamps_per_100us;
  logic [9:0]  tick_period_ms;

  lwts_pkg::slot_entry_t mem [THREAD_SLOTS];
  lwts_pkg::slot_entry_t rd_data;
  lwts_pkg::slot_entry_t wr_data;
  logic [SLOT_W-1:0]     rd_addr;
  logic [SLOT_W-1:0]     wr_addr;
  logic                  wr_en;

  logic [63:0]       previous_switch_stamp;
  logic [63:0]       now;
  logic [SLOT_W-1:0] cur_slot;
  logic              cur;
  logic [1:0]        outcome;
  logic              forced;
  lwts_pkg::slot_entry_t cur_word;

  logic [CNT_W-1:0]  rc;
  logic              pv;
  logic [SLOT_W-1:0] pidx;
  logic              have;
  logic [SLOT_W-1:0] pick;
  logic [63:0]       cbest;
  logic              phave;
  logic [SLOT_W-1:0] pslot;
  logic [63:0]       pbest;
  logic              zhave;
  logic [SLOT_W-1:0] zslot;

  logic [DCNT_W-1:0] dcnt;
  logic [63:0]       quo;
  logic [31:0]       rem;
  logic [31:0]       dvs;
  logic [32:0]       rem_sh;

  logic              accept;
  logic              slot_ok;
  logic              fslot_ok;
  logic              eligible;
  logic [63:0]       wait_ticks;
  logic              scan_issue;
  logic              scan_end;
  logic [14:0]       eater_thr;
  logic              eater;
  lwts_pkg::slot_entry_t cur_new;
  logic              fin_have;
  logic [SLOT_W-1:0] fin_pick;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign slot_ok  = 32'(slot) < 32'(THREAD_SLOTS);
  assign fslot_ok = 32'(forced_slot) < 32'(THREAD_SLOTS);
  assign eligible = pv && rd_data.used && rd_data.runnable && !rd_data.excluded;
  assign wait_ticks = now - rd_data.last_tick;
  assign scan_issue = (rc != CNT_W'(THREAD_SLOTS));
  assign scan_end   = (eligible && rd_data.last_tick == 64'd0) || (!pv && !scan_issue);
  assign eater_thr  = 15'(tick_period_ms) * lwts_pkg::EATER_SCALE + lwts_pkg::EATER_OFFSET;
  assign eater      = quo >= 64'(eater_thr);
  assign rem_sh     = {rem, quo[63]};

  always_comb begin
    cur_new = rd_data;
    cur_new.last_tick = now;
    if (outcome == lwts_pkg::OUTCOME_EXIT) begin
      cur_new.used     = 1'b0;
      cur_new.runnable = 1'b0;
      cur_new.excluded = 1'b0;
      cur_new.penalty  = 1'b0;
    end else if (outcome == lwts_pkg::OUTCOME_BLOCK) begin
      cur_new.runnable = 1'b0;
    end else begin
      cur_new.runnable = 1'b1;
    end
  end

  always_comb begin
    fin_have = have;
    fin_pick = pick;
    if (!have && phave) begin
      fin_have = 1'b1;
      fin_pick = pslot;
    end else if (!have && zhave) begin
      fin_have = 1'b1;
      fin_pick = zslot;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rc[SLOT_W-1:0];
    wr_data = '0;
    rd_addr = rc[SLOT_W-1:0];
    case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
      end
      ST_IDLE: begin
        rd_addr = SLOT_W'(slot);
        wr_addr = SLOT_W'(slot);
        wr_data = '{used: slot_in_use, runnable: runnable, excluded: no_schedule,
                    penalty: 1'b0, last_tick: last_tick};
        wr_en   = accept && kind == lwts_pkg::KIND_LOAD && slot_ok;
      end
      ST_CUR_WR: begin
        wr_addr = cur_slot;
        wr_data = cur_new;
        wr_en   = 1'b1;
      end
      ST_SCAN: begin
        wr_addr = pidx;
        wr_data = rd_data;
        wr_data.penalty = 1'b0;
        wr_en = eligible && rd_data.last_tick != 64'd0 && rd_data.last_tick != now &&
                rd_data.penalty;
      end
      ST_FINISH: begin
        wr_addr = cur_slot;
        wr_data = cur_word;
        wr_data.penalty = 1'b1;
        wr_en = !forced && cur && eater;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_shift       <= lwts_pkg::TICK_SHIFT_RST;
      stamps_per_100us <= lwts_pkg::STAMPS_RST;
      tick_period_ms   <= lwts_pkg::TICK_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lwts_pkg::REG_TICK_SHIFT:  tick_shift       <= cfg_data[5:0];
        lwts_pkg::REG_STAMPS:      stamps_per_100us <= cfg_data;
        lwts_pkg::REG_TICK_PERIOD: tick_period_ms   <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // elapsed-time divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (accept && kind == lwts_pkg::KIND_SWITCH) begin
      dcnt <= DCNT_W'(lwts_pkg::DIV_STEPS);
    end else if (dcnt != '0) begin
      dcnt <= dcnt - DCNT_W'(1);
    end
    if (accept && kind == lwts_pkg::KIND_SWITCH) begin
      quo <= timestamp - previous_switch_stamp;
      rem <= '0;
      dvs <= (stamps_per_100us == 32'd0) ? 32'd1 : stamps_per_100us;
    end else if (dcnt != '0) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= 32'(rem_sh - {1'b0, dvs});
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      rc    <= '0;
      pv    <= 1'b0;
      done  <= 1'b0;
      previous_switch_stamp <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          rc <= rc + CNT_W'(1);
          if (rc == CNT_W'(THREAD_SLOTS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && kind == lwts_pkg::KIND_SWITCH) begin
            previous_switch_stamp <= timestamp;
            now      <= timestamp >> tick_shift;
            cur_slot <= SLOT_W'(slot);
            cur      <= current_present && slot_ok;
            outcome  <= current_outcome;
            forced   <= forced_present && fslot_ok;
            have     <= forced_present && fslot_ok;
            pick     <= SLOT_W'(forced_slot);
            phave    <= 1'b0;
            zhave    <= 1'b0;
            cbest    <= '0;
            pbest    <= '0;
            rc       <= '0;
            pv       <= 1'b0;
            if (current_present && slot_ok) begin
              state <= ST_CUR_WR;
            end else if (forced_present && fslot_ok) begin
              state <= ST_WAIT;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_CUR_WR: begin
          cur_word <= cur_new;
          if (outcome == lwts_pkg::OUTCOME_EXIT) begin
            cur <= 1'b0;
          end
          state <= forced ? ST_WAIT : ST_SCAN;
        end
        ST_SCAN: begin
          pv   <= scan_issue && !scan_end;
          pidx <= rc[SLOT_W-1:0];
          if (scan_issue) begin
            rc <= rc + CNT_W'(1);
          end
          if (eligible) begin
            if (rd_data.last_tick == 64'd0) begin
              have <= 1'b1;
              pick <= pidx;
            end else if (rd_data.last_tick == now) begin
              zhave <= 1'b1;
              zslot <= pidx;
            end else if (!rd_data.penalty) begin
              if (wait_ticks > cbest) begin
                have  <= 1'b1;
                pick  <= pidx;
                cbest <= wait_ticks;
              end
            end else if (wait_ticks > pbest) begin
              phave <= 1'b1;
              pslot <= pidx;
              pbest <= wait_ticks;
            end
          end
          if (scan_end) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (dcnt == '0) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          done           <= 1'b1;
          chosen_slot    <= fin_have ? 6'(fin_pick) : 6'd0;
          chose_idle     <= !fin_have;
          eater_flagged  <= eater;
          thread_changed <= !(fin_have && cur && fin_pick == cur_slot);
          state          <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `LWTS_ASSERT(a_done_idle, done |-> state == ST_IDLE, "result while not idle")
  `LWTS_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
  `LWTS_ASSERT(a_idle_slot, done && chose_idle |-> chosen_slot == 6'd0, "idle with slot")
  `LWTS_ASSERT(a_switch_busy, accept && kind == lwts_pkg::KIND_SWITCH |=> busy,
               "switch did not raise busy")
  `LWTS_ASSERT_ALWAYS(a_reset_clear, rst |=> state == ST_CLEAR && !done,
                      "reset did not start clearing pass")

endmodule
`default_nettype wire
